// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off during reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vfd_pkg.sv =====
// Types, format codes and tables for the varint / fixed24 decoder.
`timescale 1ns / 1ps

package vfd_pkg;

    // Format codes, as carried on the input and result tuser
    localparam logic [2:0] FMT_U30 = 3'd0;
    localparam logic [2:0] FMT_U32 = 3'd1;
    localparam logic [2:0] FMT_S32 = 3'd2;
    localparam logic [2:0] FMT_U24 = 3'd3;
    localparam logic [2:0] FMT_S24 = 3'd4;

    // Decoder state between words
    typedef struct packed {
        logic [31:0] acc;
        logic [2:0]  idx;
        logic [2:0]  fmt;
    } vfd_state_t;

    // One completed value
    typedef struct packed {
        logic [31:0] value_bits;
        logic [2:0]  format;
        logic [2:0]  bytes_used;
    } vfd_res_t;

    // Outcome of one input word
    typedef struct packed {
        logic       update;   // word belongs to a value (format known)
        logic       done;     // value completes on this word
        vfd_state_t next;
        vfd_res_t   res;
    } vfd_step_t;

    // Sign fill for a signed varint ending on byte index idx (0..3)
    function automatic logic [31:0] sext_mask(input logic [2:0] idx);
        logic [31:0] m;
        unique case (idx)
            3'd0:    m = 32'hFFFF_FF80;
            3'd1:    m = 32'hFFFF_C000;
            3'd2:    m = 32'hFFE0_0000;
            3'd3:    m = 32'hF000_0000;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/vfd_step.sv =====
// Combinational decode of one stream byte against the current state.
`timescale 1ns / 1ps

module vfd_step import vfd_pkg::*; #(
    parameter int MAX_VARINT_BYTES = 5
) (
    input  logic [7:0] data_byte,
    input  logic [2:0] operation,
    input  vfd_state_t state,
    output vfd_step_t  step
);

    localparam logic [2:0] LAST_IDX = 3'(MAX_VARINT_BYTES - 1);

    logic        first;
    logic [2:0]  fmt;
    logic [31:0] acc_base;
    logic        fixed;
    logic [31:0] fixed_sh;
    logic [31:0] var_sh;
    logic [31:0] acc_or;
    logic [31:0] value;
    logic        done;

    assign first    = (state.idx == 3'd0);
    assign fmt      = first ? operation : state.fmt;
    assign acc_base = first ? 32'd0 : state.acc;
    assign fixed    = (fmt == FMT_U24) || (fmt == FMT_S24);

    // place the byte at its lane
    always_comb begin
        unique case (state.idx)
            3'd0:    fixed_sh = {24'd0, data_byte};
            3'd1:    fixed_sh = {16'd0, data_byte, 8'd0};
            default: fixed_sh = {8'd0, data_byte, 16'd0};
        endcase
        unique case (state.idx)
            3'd0:    var_sh = {25'd0, data_byte[6:0]};
            3'd1:    var_sh = {18'd0, data_byte[6:0], 7'd0};
            3'd2:    var_sh = {11'd0, data_byte[6:0], 14'd0};
            3'd3:    var_sh = {4'd0, data_byte[6:0], 21'd0};
            default: var_sh = {data_byte[3:0], 28'd0};
        endcase
    end

    assign acc_or = acc_base | (fixed ? fixed_sh : var_sh);

    // completion and sign handling
    always_comb begin
        value = acc_or;
        done  = 1'b0;
        if (fixed) begin
            done = (state.idx >= 3'd2);
            if (fmt == FMT_S24 && acc_or[23]) begin
                value[31:24] = 8'hFF;
            end
        end else if (!data_byte[7]) begin
            done = 1'b1;
            if (fmt == FMT_S32 && data_byte[6] && state.idx < 3'd4) begin
                value = acc_or | sext_mask(state.idx);
            end
        end else begin
            done = (state.idx >= LAST_IDX);
        end
        if (fmt == FMT_U30) begin
            value[31:30] = 2'b00;
        end
    end

    // unknown format on a first byte drops the word
    assign step.update         = !(first && operation > FMT_S24);
    assign step.done           = step.update && done;
    assign step.next.acc       = done ? 32'd0 : acc_or;
    assign step.next.idx       = done ? 3'd0 : state.idx + 3'd1;
    assign step.next.fmt       = fmt;
    assign step.res.value_bits = value;
    assign step.res.format     = fmt;
    assign step.res.bytes_used = state.idx + 3'd1;

endmodule

// ===== rtl/core/vfd_out_reg.sv =====
// Result register on the master side; frees itself as the word is taken.
`timescale 1ns / 1ps

module vfd_out_reg import vfd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  vfd_res_t res_in,
    output logic     space,
    output logic     m_tvalid,
    input  logic     m_tready,
    output vfd_res_t res_out
);

    logic     valid_reg;
    logic     valid_next;
    vfd_res_t res_reg;

    assign space      = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    // handshake state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

endmodule

// ===== rtl/core/varint_and_fixed24_decoder.sv =====
// A value's result is registered and shown in the cycle after its last byte is accepted.
// One byte is taken per cycle while s_tready is high; the decode of a byte is one combinational pass
// from the state registers into the state and result registers.
// s_tready drops only while a result waits and m_tready is low.
// Reset (aresetn low, synchronous) clears the byte count, format and result valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module varint_and_fixed24_decoder import vfd_pkg::*; #(
    parameter int MAX_VARINT_BYTES = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value_bits, [34:32] bytes_used, rest zero
    output logic [2:0]  m_tuser    // [2:0] format
);

    localparam logic [2:0] LAST_IDX  = 3'(MAX_VARINT_BYTES - 1);
    localparam logic [2:0] MAX_BYTES = 3'(MAX_VARINT_BYTES);

    vfd_state_t state_reg;
    vfd_state_t state_next;
    vfd_step_t  step;
    vfd_res_t   res_q;
    logic       space;
    logic       accept;
    logic       load;
    logic       state_fixed;
    logic       res_fixed;
    logic       res_len_ok;

    assign s_tready = space;
    assign accept   = s_tvalid && space;
    assign load     = accept && step.done;

    vfd_step #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_step (
        .data_byte(s_tdata),
        .operation(s_tuser),
        .state    (state_reg),
        .step     (step)
    );

    // decoder state
    assign state_next = (accept && step.update) ? step.next : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    vfd_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .res_in  (step.res),
        .space   (space),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .res_out (res_q)
    );

    assign m_tdata = {5'd0, res_q.bytes_used, res_q.value_bits};
    assign m_tuser = res_q.format;

    // checks
    assign state_fixed = (state_reg.fmt == FMT_U24) || (state_reg.fmt == FMT_S24);
    assign res_fixed   = (res_q.format == FMT_U24) || (res_q.format == FMT_S24);
    assign res_len_ok  = (res_q.bytes_used != 3'd0) && (res_q.bytes_used <= MAX_BYTES);

    `ASSERT_ALWAYS(a_fixed_idx, aclk, aresetn, !(state_fixed && state_reg.idx > 3'd2), "fixed index past 2")
    `ASSERT_ALWAYS(a_var_idx, aclk, aresetn, state_fixed || state_reg.idx <= LAST_IDX, "varint index past limit")
    `ASSERT_NEXT(a_done_clears, aclk, aresetn, load, state_reg.idx == 3'd0 && m_tvalid, "no clear after done")
    `ASSERT_ALWAYS(a_fixed_len, aclk, aresetn, !(m_tvalid && res_fixed && res_q.bytes_used != 3'd3), "fixed length not 3")
    `ASSERT_ALWAYS(a_len_range, aclk, aresetn, !m_tvalid || res_fixed || res_len_ok, "bytes_used out of range")

endmodule

// ===== sim/vfd_checker.sv =====
// Checker for the varint / fixed24 decoder: predicts each value from the input words.
`timescale 1ns / 1ps

module vfd_checker import vfd_pkg::*; #(
    parameter int MAX_VARINT_BYTES = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_tuser,   // [2:0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] value_bits, [34:32] bytes_used, rest zero
    input  logic [2:0]  m_tuser,   // [2:0] format
    output int          fail_count,
    output int          pending
);

    // Mirror of the decoder state
    logic [31:0] acc_q;
    logic [2:0]  idx_q;
    logic [2:0]  fmt_q;

    // Values predicted but not yet seen on the result channel
    vfd_res_t values_due[$];

    // Fold one accepted word into the mirrored state; queue a value when it completes
    task automatic decode_byte(input logic [7:0] b, input logic [2:0] op);
        logic [2:0]  pos;
        logic [31:0] payload;
        logic        done;
        vfd_res_t    r;
        done = 1'b0;
        if (idx_q == 3'd0) begin
            // unknown format on a first byte: word is dropped
            if (op > FMT_S24) return;
            fmt_q = op;
            acc_q = '0;
        end
        pos = (idx_q > 3'd4) ? 3'd4 : idx_q;
        if (fmt_q == FMT_U24 || fmt_q == FMT_S24) begin
            if (pos > 3'd2) pos = 3'd2;
            payload = {24'd0, b};
            acc_q |= payload << (8 * pos);
            if (pos == 3'd2) begin
                done = 1'b1;
                if (fmt_q == FMT_S24 && acc_q[23]) acc_q[31:24] = 8'hFF;
            end
        end else begin
            payload = {25'd0, b[6:0]};
            acc_q |= payload << (7 * pos);
            if (!b[7]) begin
                done = 1'b1;
                // LEB128 sign fill from the last payload bit, not on the fifth byte
                if (fmt_q == FMT_S32 && b[6] && pos < 3'd4)
                    acc_q |= 32'hFFFF_FFFF << (7 * (pos + 1));
            end else if (pos + 1 >= MAX_VARINT_BYTES) begin
                // length limit ends the value even with bit 7 set
                done = 1'b1;
            end
        end
        if (!done) begin
            idx_q = pos + 3'd1;
            return;
        end
        r.value_bits = (fmt_q == FMT_U30) ? (acc_q & 32'h3FFF_FFFF) : acc_q;
        r.format     = fmt_q;
        r.bytes_used = pos + 3'd1;
        values_due.push_back(r);
        acc_q = '0;
        idx_q = '0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            acc_q      = '0;
            idx_q      = '0;
            fmt_q      = '0;
            fail_count = 0;
            values_due.delete();
        end else begin
            // result side first, so a stray word cannot match a value queued this edge
            if (m_tvalid && m_tready) begin
                if (values_due.size() == 0) begin
                    $display("%0t: unexpected value word: value %h format %0d bytes %0d",
                             $time, m_tdata[31:0], m_tuser, m_tdata[34:32]);
                    fail_count++;
                end else begin
                    vfd_res_t want;
                    want = values_due.pop_front();
                    if (m_tdata[31:0] !== want.value_bits) begin
                        $display("%0t: value_bits mismatch: expected %h actual %h",
                                 $time, want.value_bits, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tuser !== want.format) begin
                        $display("%0t: format mismatch: expected %0d actual %0d",
                                 $time, want.format, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[34:32] !== want.bytes_used) begin
                        $display("%0t: bytes_used mismatch: expected %0d actual %0d",
                                 $time, want.bytes_used, m_tdata[34:32]);
                        fail_count++;
                    end
                    if (m_tdata[39:35] !== 5'd0) begin
                        $display("%0t: tdata padding mismatch: expected %h actual %h",
                                 $time, 5'd0, m_tdata[39:35]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
        end
        pending = values_due.size();
    end

endmodule

// ===== sim/varint_and_fixed24_decoder_tb.sv =====
// Testbench top for the varint / fixed24 decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module varint_and_fixed24_decoder_tb import vfd_pkg::*;;

    localparam int         MAX_VARINT_BYTES = 5;
    localparam int         N_BYTES          = 1250;
    localparam int         IDLE_LIMIT       = 5000;
    localparam int         TAIL_CYCLES      = 10;
    // format codes the decoder does not know
    localparam logic [2:0] FMT_RSVD_LO      = 3'd5;
    localparam logic [2:0] FMT_RSVD_HI      = 3'd7;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] data_byte
    logic [2:0]  s_tuser  = 3'd0;   // [2:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [31:0] value_bits, [34:32] bytes_used, rest zero
    logic [2:0]  m_tuser;           // [2:0] format

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int stall_left  = 0;
    int bytes_sent  = 0;
    bit quiet       = 1'b0;

    always #5 aclk = ~aclk;

    varint_and_fixed24_decoder #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    vfd_checker #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) value_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0 && pick_gap() > 0) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("varint_and_fixed24_decoder regression: fail");
            $finish;
        end
    end

    // Present one word after a random gap and hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic [2:0] op);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // One encoded value, byte i in raw[8*i +: 8]; later bytes carry a random format
    task automatic send_value(input logic [2:0] op, input int n, input logic [39:0] raw);
        for (int i = 0; i < n; i++)
            send_word(raw[8*i +: 8], (i == 0) ? op : 3'($urandom_range(0, 7)));
        bytes_sent += n;
    endtask

    // Hold off the sender until every predicted value has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    initial begin
        logic [2:0]  op;
        logic [39:0] raw;
        int          n;
        int          sel;
        bit          drained_mid;
        drained_mid = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, sign fill at lengths 1, 2 and 4, length limit, unknown format
        send_value(FMT_U30, 5, 40'h7F_FF_FF_FF_FF);   // u30 drops bits 30 and 31
        send_value(FMT_S32, 1, 40'h00_00_00_00_40);   // sign from bit 6
        send_value(FMT_S32, 2, 40'h00_00_00_40_80);   // sign from bit 13
        send_value(FMT_S32, 4, 40'h00_40_80_80_80);   // sign from bit 27
        send_value(FMT_S32, 5, 40'hFF_80_80_80_80);   // fifth byte, bit 7 set, no fill
        send_value(FMT_U32, 1, 40'h00_00_00_00_00);
        send_word(8'hFF, FMT_RSVD_HI);                // dropped first byte
        send_value(FMT_U24, 3, 40'h00_00_FF_FF_FF);
        send_value(FMT_S24, 3, 40'h00_00_80_00_00);   // negative 24-bit
        drain();

        // random: mostly well-formed values, some noise and stray bytes
        while (bytes_sent < N_BYTES) begin
            if (!drained_mid && bytes_sent >= N_BYTES / 2) begin
                drain();
                drained_mid = 1'b1;
            end
            if ($urandom_range(0, 99) < 2) quiet = !quiet;
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
                op  = 3'($urandom_range(FMT_U30, FMT_S24));
                raw = 40'({$urandom, $urandom});
                if (op == FMT_U24 || op == FMT_S24) begin
                    n = 3;
                end else begin
                    n = $urandom_range(1, MAX_VARINT_BYTES);
                    for (int i = 0; i < n - 1; i++) raw[8*i + 7] = 1'b1;
                    if (n < MAX_VARINT_BYTES) raw[8*(n-1) + 7] = 1'b0;
                end
                send_value(op, n, raw);
            end else if (sel < 93) begin
                send_word(8'($urandom), 3'($urandom_range(FMT_RSVD_LO, FMT_RSVD_HI)));
            end else begin
                send_word(8'($urandom), 3'($urandom_range(0, 7)));
                bytes_sent++;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("varint_and_fixed24_decoder regression: pass");
        else
            $display("varint_and_fixed24_decoder regression: fail");
        $finish;
    end

endmodule
